/* sv/nsm_pkg.sv */
package nsm_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_DEV,
      ST_DEVINS,
      ST_FINISH
   } back_state_type;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               store;
      logic               last;
      logic               overflow;
   } item_type;

   localparam int QUEUE_DEPTH = 2;

endpackage

/* sv/nsm_front.sv */
module nsm_front #(
   parameter int MAX_SAMPLES = 128,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_sample,
   input  logic                req_skip,
   input  logic                req_last,
   output logic                q_valid,
   output nsm_pkg::item_type   q_item,
   input  logic                q_pop
);
   localparam int CW = $clog2(MAX_SAMPLES + 2);
   localparam int SW = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;

   logic [CW-1:0] item_count_ff, item_count_in;
   logic          ovf_ff, ovf_in;
   nsm_pkg::item_type q_ff [nsm_pkg::QUEUE_DEPTH];
   logic [1:0]    fill_ff, fill_in;
   logic          accept, ovf_now;
   nsm_pkg::item_type new_item;

   assign busy   = (fill_ff == 2'(nsm_pkg::QUEUE_DEPTH));
   assign accept = start && !busy;

   always_comb begin
      item_count_in = item_count_ff;
      if (item_count_ff <= CW'(MAX_SAMPLES)) begin
         item_count_in = item_count_ff + 1'b1;
      end
      ovf_now = ovf_ff || (item_count_in > CW'(MAX_SAMPLES));
      new_item.sample   = 32'(signed'(req_sample[SW-1:0]));
      new_item.store    = !req_skip && !ovf_now;
      new_item.last     = req_last;
      new_item.overflow = ovf_now;
      ovf_in = ovf_now;
      if (req_last) begin
         item_count_in = '0;
         ovf_in        = 1'b0;
      end
      fill_in = fill_ff + 2'(accept) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
         ovf_ff        <= 1'b0;
         fill_ff       <= '0;
      end else begin
         if (accept) begin
            item_count_ff <= item_count_in;
            ovf_ff        <= ovf_in;
         end
         fill_ff <= fill_in;
      end
   end

   // two-entry shift queue, head in entry 0
   always_ff @(posedge clock) begin
      if (q_pop) begin
         q_ff[0] <= q_ff[1];
      end
      if (accept) begin
         if (q_pop) begin
            if (fill_ff == 2'd1) q_ff[0] <= new_item;
            else q_ff[1] <= new_item;
         end else begin
            if (fill_ff == 2'd0) q_ff[0] <= new_item;
            else q_ff[1] <= new_item;
         end
      end
   end

   assign q_valid = (fill_ff != 2'd0);
   assign q_item  = q_ff[0];

`ifndef ASSERT_OFF
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(nsm_pkg::QUEUE_DEPTH)) else $error("queue overfilled");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      item_count_ff <= CW'(MAX_SAMPLES + 1)) else $error("item count past limit");
`endif
endmodule

/* sv/nsm_back.sv */
module nsm_back #(
   parameter int MAX_SAMPLES = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mode,
   input  logic                      q_valid,
   input  nsm_pkg::item_type         q_item,
   output logic                      q_pop,
   output logic                      rsp_valid,
   output logic signed [35:0]        rsp_result_quarters,
   output logic                      rsp_empty_res,
   output logic                      rsp_too_many
);
   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int NW = $clog2(MAX_SAMPLES + 1);

   nsm_pkg::back_state_type state_ff, state_in;

   // two stores: samples and deviations; each read/write one address a cycle
   logic signed [33:0] mem_s [MAX_SAMPLES];
   logic signed [33:0] mem_d [MAX_SAMPLES];

   logic [NW-1:0]      n_ff, n_in;
   logic [NW-1:0]      j_ff, j_in;   // insertion position
   logic [NW-1:0]      i_ff, i_in;   // deviation index / finish step
   logic signed [33:0] x_ff, x_in;
   logic               last_ff, last_in, ovf_ff, ovf_in, dst_ff, dst_in;
   logic signed [35:0] med2_ff, med2_in;
   logic signed [35:0] acc_ff, acc_in;
   logic [1:0]         ph_ff, ph_in;

   logic [AW-1:0]      raddr;
   logic               rsel;
   logic signed [33:0] rdata_s_ff, rdata_d_ff, rdata;
   logic               we;
   logic [AW-1:0]      waddr;
   logic signed [33:0] wdata;

   logic               out_v_in;
   logic signed [35:0] out_r_in;
   logic               out_e_in, out_t_in;
   logic signed [35:0] dv;

   assign rdata = rsel ? rdata_d_ff : rdata_s_ff;

   always_ff @(posedge clock) begin
      rdata_s_ff <= mem_s[raddr];
      rdata_d_ff <= mem_d[raddr];
      if (we && !dst_ff) mem_s[waddr] <= wdata;
      if (we && dst_ff)  mem_d[waddr] <= wdata;
   end

   // insertion: ph 0 issues read of j-1, ph 1 compares and shifts
   always_comb begin
      state_in = state_ff;
      n_in = n_ff; j_in = j_ff; i_in = i_ff; x_in = x_ff;
      last_in = last_ff; ovf_in = ovf_ff; dst_in = dst_ff;
      med2_in = med2_ff; acc_in = acc_ff; ph_in = ph_ff;
      q_pop = 1'b0;
      raddr = AW'(j_ff - 1'b1);
      rsel  = dst_ff;
      we = 1'b0; waddr = AW'(j_ff); wdata = x_ff;
      out_v_in = 1'b0; out_r_in = '0; out_e_in = 1'b0; out_t_in = 1'b0;
      dv = 36'(x_ff);
      case (state_ff)
         nsm_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               x_in    = 34'(q_item.sample);
               last_in = q_item.last;
               ovf_in  = q_item.overflow;
               dst_in  = 1'b0;
               j_in    = n_ff;
               ph_in   = 2'd0;
               if (q_item.store && n_ff < NW'(MAX_SAMPLES)) begin
                  state_in = nsm_pkg::ST_INSERT;
               end else if (q_item.last) begin
                  state_in = nsm_pkg::ST_FINISH;
                  i_in = '0;
               end
            end
         end
         nsm_pkg::ST_INSERT: begin
            if (ph_ff == 2'd0) begin
               if (j_ff == '0) begin
                  we = 1'b1;
                  ph_in = 2'd2;
               end else begin
                  ph_in = 2'd1;
               end
            end else if (ph_ff == 2'd1) begin
               if (rdata > x_ff) begin
                  we = 1'b1; wdata = rdata;
                  j_in = j_ff - 1'b1;
                  ph_in = 2'd0;
               end else begin
                  we = 1'b1;
                  ph_in = 2'd2;
               end
            end else begin
               ph_in = 2'd0;
               if (!dst_ff) begin
                  n_in = n_ff + 1'b1;
                  state_in = last_ff ? nsm_pkg::ST_FINISH : nsm_pkg::ST_IDLE;
                  i_in = '0;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = (i_ff + 1'b1 == n_ff) ? nsm_pkg::ST_FINISH
                                                   : nsm_pkg::ST_DEV;
                  if (i_ff + 1'b1 == n_ff) i_in = '0;
               end
            end
         end
         nsm_pkg::ST_DEV: begin
            // read sample i, then insert its deviation into the deviation store
            rsel = 1'b0;
            raddr = AW'(i_ff);
            if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else begin
               dv = 36'(2 * 36'(rdata)) - med2_ff;
               if (dv < 0) dv = -dv;
               x_in = 34'(dv);
               j_in = i_ff;
               ph_in = 2'd0;
               state_in = nsm_pkg::ST_DEVINS;
            end
         end
         nsm_pkg::ST_DEVINS: begin
            state_in = nsm_pkg::ST_INSERT;
         end
         nsm_pkg::ST_FINISH: begin
            // steps: read a[h-1], read a[h], combine
            rsel = dst_ff;
            if (i_ff == '0) begin
               raddr = AW'((n_ff >> 1) - 1'b1);
               if (ovf_ff || n_ff == '0) begin
                  out_v_in = 1'b1;
                  out_t_in = ovf_ff;
                  out_e_in = !ovf_ff;
                  n_in = '0;
                  state_in = nsm_pkg::ST_IDLE;
               end else begin
                  i_in = NW'(1);
               end
            end else if (i_ff == NW'(1)) begin
               raddr = AW'(n_ff >> 1);
               acc_in = n_ff[0] ? 36'sd0 : 36'(rdata);
               i_in = NW'(2);
            end else if (i_ff == NW'(2)) begin
               raddr = AW'(n_ff >> 1);
               i_in = NW'(3);
            end else begin
               if (n_ff[0]) med2_in = 36'(2 * 36'(rdata));
               else med2_in = acc_ff + 36'(rdata);
               if (!mode || dst_ff) begin
                  out_v_in = 1'b1;
                  out_r_in = dst_ff ? med2_in : 36'(2 * med2_in);
                  n_in = '0;
                  state_in = nsm_pkg::ST_IDLE;
               end else begin
                  dst_in = 1'b1;
                  i_in = '0;
                  ph_in = 2'd0;
                  state_in = nsm_pkg::ST_DEV;
               end
            end
         end
         default: state_in = nsm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= nsm_pkg::ST_IDLE;
         n_ff      <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         n_ff      <= n_in;
         rsp_valid <= out_v_in;
      end
      j_ff <= j_in; i_ff <= i_in; x_ff <= x_in;
      last_ff <= last_in; ovf_ff <= ovf_in; dst_ff <= dst_in;
      med2_ff <= med2_in; acc_ff <= acc_in; ph_ff <= ph_in;
      rsp_result_quarters <= out_r_in;
      rsp_empty_res <= out_e_in;
      rsp_too_many  <= out_t_in;
   end

`ifndef ASSERT_OFF
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_empty_res && rsp_too_many)) else $error("both flags");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(MAX_SAMPLES)) else $error("store count past capacity");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == nsm_pkg::ST_IDLE) else $error("pop while working");
`endif
endmodule

/* sv/nan_skipping_median_and_mad.sv */
// a sample passes through the insertion loop over the sorted store
// (one read, one compare and shift per entry passed); a last item adds the finish steps,
// and in deviation mode a further pass for the deviation insertion
// throughput: one item accepted per cycle until the two-entry queue is full
// results cannot be stalled; rsp_valid is high for one cycle
// reset: synchronous, clears batch counters and mode; store contents are not cleared
module nan_skipping_median_and_mad #(
   parameter int MAX_SAMPLES = 128,
   parameter int SAMPLE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_sample,
   input  logic               req_skip,
   input  logic               req_last,
   output logic               rsp_valid,
   output logic signed [35:0] rsp_result_quarters,
   output logic               rsp_empty_res,
   output logic               rsp_too_many,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   logic              mode_ff;
   logic              q_valid, q_pop;
   nsm_pkg::item_type q_item;

   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? {31'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (psel && penable && pwrite && paddr == 2'd0) begin
         mode_ff <= pwdata[0];
      end
   end

   nsm_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock, .reset, .start, .busy, .req_sample, .req_skip, .req_last,
      .q_valid, .q_item, .q_pop
   );

   nsm_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
      .clock, .reset, .mode(mode_ff), .q_valid, .q_item, .q_pop,
      .rsp_valid, .rsp_result_quarters, .rsp_empty_res, .rsp_too_many
   );
endmodule
